FILE: hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the converter checker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hdl/rgbnv_pkg.sv
// -----------------------------------------------------------------------------
// rgbnv_pkg
// Constants, codes, stage types and helpers of the RGB to NV12 converter.
// -----------------------------------------------------------------------------
package rgbnv_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int SIZE_W      = 13;
   localparam int SUM_W       = 9;
   localparam int ENTRY_W     = 2 * SUM_W;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_PIXEL_ORDER  = 2'd0;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

   // Pixel byte orders.
   localparam logic [1:0] ORDER_BGR = 2'd0;
   localparam logic [1:0] ORDER_RGB = 2'd1;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

   // BT.601 studio range coefficients (scaled by 256).
   localparam logic [15:0] COEF_Y_R  = 16'd66;
   localparam logic [15:0] COEF_Y_G  = 16'd129;
   localparam logic [15:0] COEF_Y_B  = 16'd25;
   localparam logic [15:0] COEF_U_R  = 16'd38;
   localparam logic [15:0] COEF_U_G  = 16'd74;
   localparam logic [15:0] COEF_UV_P = 16'd112;
   localparam logic [15:0] COEF_V_G  = 16'd94;
   localparam logic [15:0] COEF_V_B  = 16'd18;
   localparam logic [15:0] ROUND_Y   = 16'd128;
   localparam logic [15:0] ROUND_UV  = 16'd32896;
   localparam logic [8:0]  LUMA_OFS  = 9'd16;
   localparam logic [8:0]  BYTE_MAX  = 9'd255;

   typedef struct packed {
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic              odd_col;
      logic              odd_row;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } pix_stage_type;

   typedef struct packed {
      logic [7:0]         luma;
      logic [7:0]         u;
      logic [7:0]         v;
      logic               odd_col;
      logic               odd_row;
      logic [SLOT_W-1:0]  slot;
      logic               last;
      logic [ENTRY_W-1:0] stored;
   } yuv_stage_type;

   // Frame size in use: bit 0 cleared, then held within 2..limit.
   function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] value,
                                                        input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] s;
      s = {value[SIZE_W-1:1], 1'b0};
      if (s < SIZE_W'(2)) begin
         s = SIZE_W'(2);
      end
      if (s > limit) begin
         s = {limit[SIZE_W-1:1], 1'b0};
      end
      return s;
   endfunction

   function automatic logic [7:0] clamp_byte(input logic [8:0] value);
      return (value > BYTE_MAX) ? 8'hFF : value[7:0];
   endfunction

endpackage

FILE: hdl/rgb_to_nv12_converter_top.sv
// -----------------------------------------------------------------------------
// rgb_to_nv12_converter_top
// Packed RGB/BGR pixel stream to BT.601 studio range luma and 2x2 chroma.
// -----------------------------------------------------------------------------
// The converter takes one pixel per clock in raster order and returns one item per
// pixel: its luma, and on the second pixel of each pair in an odd line the averaged
// U and V of the 2x2 block (flagged in rsp_tuser, zero otherwise), with rsp_tlast on
// the last pixel of the frame. Sustained rate is one item per clock cycle; an item
// passes stages s0 and s1 before it reaches the output register, and the pipeline
// only holds when the output item is not taken. Even-line pair sums of U and V live
// in a 2048 x 18 line store (one entry per pixel pair) that is read when the pixel is
// accepted and written two stages later, with a bypass for the case where the write
// and the read of the same entry fall on the same edge (frames two pixels wide).
// The store needs no clearing pass; every entry is written in an even line before
// the odd line reads it. Pixels taken while the byte order register holds an
// unsupported code are dropped and leave the position unchanged. A write to one of
// the three registers restarts the frame; write registers only while no item is
// in flight. Frame sizes are used with bit 0 cleared and held within 2..4096.
module rgb_to_nv12_converter_top (
   input  logic        clock,
   input  logic        reset,
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   // Pixel input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // first_byte [7:0], second_byte [15:8], third_byte [23:16]
   // Result output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // luma [7:0], chroma_u [15:8], chroma_v [23:16]
   output logic [0:0]  rsp_tuser,  // chroma_valid [0]
   output logic        rsp_tlast   // frame_end
);

   // Configuration registers; sizes are kept in their effective form.
   logic [1:0]                     order_ff;
   logic [rgbnv_pkg::SIZE_W-1:0]   width_ff;
   logic [rgbnv_pkg::SIZE_W-1:0]   height_ff;
   logic                           restart;

   // Frame position.
   logic [rgbnv_pkg::COL_W-1:0]    col_ff, col_in;
   logic [rgbnv_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                           last_in;

   // Pipeline stages.
   logic                           s0_valid_ff;
   rgbnv_pkg::pix_stage_type       s0_ff, s0_in;
   logic                           s1_valid_ff;
   rgbnv_pkg::yuv_stage_type       s1_ff, s1_in;

   // Output register.
   logic                           rsp_valid_ff;
   logic [7:0]                     luma_ff, cu_ff, cv_ff, cu_in, cv_in;
   logic                           cvalid_ff, cvalid_in;
   logic                           last_ff;

   // Pending U and V of the first pixel of the current pair.
   logic [7:0]                     pend_u_ff, pend_v_ff;

   // Flow control.
   logic                           out_free, s1_free, s1_move, s0_move;
   logic                           accept, load_s0, order_ok;

   // Line store access.
   logic                               ram_we, ram_re;
   logic [rgbnv_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;
   logic                               fwd_hit_ff;
   logic [rgbnv_pkg::ENTRY_W-1:0]      fwd_data_ff;
   logic [rgbnv_pkg::SUM_W-1:0]        pair_u, pair_v;

   // Color arithmetic.
   logic [15:0]                    y_sum, u_pos, u_neg, u_diff, v_pos, v_neg, v_diff;
   logic [8:0]                     luma_wide;
   logic [10:0]                    quad_u, quad_v;

   // ---------------------------------------------------------------------------
   // Configuration.
   // ---------------------------------------------------------------------------
   assign restart = csr_wr_en && (csr_index == rgbnv_pkg::REG_PIXEL_ORDER ||
                                  csr_index == rgbnv_pkg::REG_FRAME_WIDTH ||
                                  csr_index == rgbnv_pkg::REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff  <= rgbnv_pkg::ORDER_BGR;
         width_ff  <= rgbnv_pkg::WIDTH_RESET;
         height_ff <= rgbnv_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rgbnv_pkg::REG_PIXEL_ORDER: begin
               order_ff <= csr_wdata[1:0];
            end
            rgbnv_pkg::REG_FRAME_WIDTH: begin
               width_ff <= rgbnv_pkg::effective_size(csr_wdata,
                              rgbnv_pkg::SIZE_W'(rgbnv_pkg::MAX_WIDTH));
            end
            rgbnv_pkg::REG_FRAME_HEIGHT: begin
               height_ff <= rgbnv_pkg::effective_size(csr_wdata,
                               rgbnv_pkg::SIZE_W'(rgbnv_pkg::MAX_HEIGHT));
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Flow control: each stage moves on when the stage after it is free or moving.
   // ---------------------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_free    = !s1_valid_ff || out_free;
   assign s1_move    = s1_valid_ff && out_free;
   assign s0_move    = s0_valid_ff && s1_free;
   assign req_tready = !s0_valid_ff || s1_free;
   assign accept     = req_tvalid && req_tready;
   assign order_ok   = (order_ff == rgbnv_pkg::ORDER_BGR) || (order_ff == rgbnv_pkg::ORDER_RGB);
   assign load_s0    = accept && order_ok;

   // ---------------------------------------------------------------------------
   // Accept: byte order, position in the frame.
   // ---------------------------------------------------------------------------
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      last_in = 1'b0;
      if ((rgbnv_pkg::SIZE_W'(col_ff) + rgbnv_pkg::SIZE_W'(1)) >= width_ff) begin
         col_in = '0;
         if ((rgbnv_pkg::SIZE_W'(row_ff) + rgbnv_pkg::SIZE_W'(1)) >= height_ff) begin
            row_in  = '0;
            last_in = 1'b1;
         end else begin
            row_in = row_ff + rgbnv_pkg::ROW_W'(1);
         end
      end else begin
         col_in = col_ff + rgbnv_pkg::COL_W'(1);
      end

      s0_in.green   = req_tdata[15:8];
      if (order_ff == rgbnv_pkg::ORDER_RGB) begin
         s0_in.red  = req_tdata[7:0];
         s0_in.blue = req_tdata[23:16];
      end else begin
         s0_in.blue = req_tdata[7:0];
         s0_in.red  = req_tdata[23:16];
      end
      s0_in.odd_col = col_ff[0];
      s0_in.odd_row = row_ff[0];
      s0_in.slot    = col_ff[rgbnv_pkg::COL_W-1:1];
      s0_in.last    = last_in;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (load_s0) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (load_s0) begin
         s0_valid_ff <= 1'b1;
      end else if (s0_move) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s0) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Line store. The odd line reads its pair entry when the pixel is accepted;
   // the even line writes it as the pixel leaves the second stage.
   // ---------------------------------------------------------------------------
   assign ram_re = load_s0 && col_ff[0] && row_ff[0];
   assign ram_we = s1_move && s1_ff.odd_col && !s1_ff.odd_row;

   rgbnv_ram #(
      .WIDTH (rgbnv_pkg::ENTRY_W),
      .DEPTH (rgbnv_pkg::STORE_DEPTH)
   ) u_pair_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_ff.slot),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (s0_in.slot),
      .rd_data (ram_rdata)
   );

   // A write and a read of the same entry on one edge: the read gets the new data.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (ram_re) begin
         fwd_hit_ff <= ram_we && (s1_ff.slot == s0_in.slot);
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         fwd_data_ff <= ram_wdata;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: luma and per-pixel chroma. The U and V sums carry a bias of
   // 128 * 256, so they stay positive and the upper byte is the floor shift.
   // ---------------------------------------------------------------------------
   always_comb begin
      y_sum  = 16'(s0_ff.red) * rgbnv_pkg::COEF_Y_R + 16'(s0_ff.green) * rgbnv_pkg::COEF_Y_G
             + 16'(s0_ff.blue) * rgbnv_pkg::COEF_Y_B + rgbnv_pkg::ROUND_Y;
      u_pos  = 16'(s0_ff.blue) * rgbnv_pkg::COEF_UV_P + rgbnv_pkg::ROUND_UV;
      u_neg  = 16'(s0_ff.red) * rgbnv_pkg::COEF_U_R + 16'(s0_ff.green) * rgbnv_pkg::COEF_U_G;
      u_diff = u_pos - u_neg;
      v_pos  = 16'(s0_ff.red) * rgbnv_pkg::COEF_UV_P + rgbnv_pkg::ROUND_UV;
      v_neg  = 16'(s0_ff.green) * rgbnv_pkg::COEF_V_G + 16'(s0_ff.blue) * rgbnv_pkg::COEF_V_B;
      v_diff = v_pos - v_neg;
      luma_wide = {1'b0, y_sum[15:8]} + rgbnv_pkg::LUMA_OFS;

      s1_in.luma    = rgbnv_pkg::clamp_byte(luma_wide);
      s1_in.u       = u_diff[15:8];
      s1_in.v       = v_diff[15:8];
      s1_in.odd_col = s0_ff.odd_col;
      s1_in.odd_row = s0_ff.odd_row;
      s1_in.slot    = s0_ff.slot;
      s1_in.last    = s0_ff.last;
      s1_in.stored  = fwd_hit_ff ? fwd_data_ff : ram_rdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s0_move) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_move) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: pair sums, 2x2 averages and the output register.
   // ---------------------------------------------------------------------------
   always_comb begin
      pair_u    = rgbnv_pkg::SUM_W'(pend_u_ff) + rgbnv_pkg::SUM_W'(s1_ff.u);
      pair_v    = rgbnv_pkg::SUM_W'(pend_v_ff) + rgbnv_pkg::SUM_W'(s1_ff.v);
      ram_wdata = {pair_v, pair_u};

      quad_u = 11'(s1_ff.stored[rgbnv_pkg::SUM_W-1:0]) + 11'(pend_u_ff) + 11'(s1_ff.u);
      quad_v = 11'(s1_ff.stored[rgbnv_pkg::ENTRY_W-1:rgbnv_pkg::SUM_W])
             + 11'(pend_v_ff) + 11'(s1_ff.v);

      cvalid_in = s1_ff.odd_col && s1_ff.odd_row;
      if (cvalid_in) begin
         cu_in = rgbnv_pkg::clamp_byte(quad_u[10:2]);
         cv_in = rgbnv_pkg::clamp_byte(quad_v[10:2]);
      end else begin
         cu_in = 8'd0;
         cv_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pend_u_ff <= 8'd0;
         pend_v_ff <= 8'd0;
      end else if (s1_move && !s1_ff.odd_col) begin
         pend_u_ff <= s1_ff.u;
         pend_v_ff <= s1_ff.v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         luma_ff   <= s1_ff.luma;
         cu_ff     <= cu_in;
         cv_ff     <= cv_in;
         cvalid_ff <= cvalid_in;
         last_ff   <= s1_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cv_ff, cu_ff, luma_ff};
   assign rsp_tuser  = cvalid_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: hdl/rgbnv_ram.sv
// -----------------------------------------------------------------------------
// rgbnv_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
module rgbnv_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rgbnv_checker.sv
// -----------------------------------------------------------------------------
// rgbnv_checker
// Port-level checks of the RGB to NV12 converter, bound to its top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbnv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A waiting output item stays offered until it is taken.
   `ASSERT_CLK_RST(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // Chroma fields are zero on items that do not complete a 2x2 block.
   `ASSERT_CLK_RST(chroma_zero_a, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[23:8] == 16'd0)

   // Studio range luma always falls within 16..235.
   `ASSERT_CLK_RST(luma_range_a, clock, reset, rsp_tvalid |-> rsp_tdata[7:0] >= 8'd16 && rsp_tdata[7:0] <= 8'd235)

   // Frames have an even line count, so the last pixel always completes a block.
   `ASSERT_CLK_RST(last_block_a, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tuser[0])

   // Nothing is offered in the cycle after reset.
   `ASSERT_CLK(reset_empty_a, clock, reset |=> !rsp_tvalid)

endmodule

bind rgb_to_nv12_converter_top rgbnv_checker u_rgbnv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/rgb_to_nv12_converter_top_tb.sv
// -----------------------------------------------------------------------------
// rgb_to_nv12_converter_top_tb
// Self-checking bench for the RGB to NV12 pixel converter. A behavioral
// predictor tracks the frame position and the 2x2 chroma sums, and every result
// item is compared field by field against it while both stream sides stall at
// random and the frame size and byte order change between phases.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_nv12_converter_top_tb;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PIXELS = 1800;

   // Codes the package does not name: the two unsupported byte orders and the
   // unused fourth register index.
   localparam logic [1:0] ORDER_NONE_A = 2'd2;
   localparam logic [1:0] ORDER_NONE_B = 2'd3;
   localparam logic [1:0] REG_UNUSED   = 2'd3;

   // One expected result item.
   typedef struct {
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       chroma_valid;
      logic       frame_end;
   } nv12_sample_type;

   // Scoreboard: copies the registers, the frame position, the pending pair sums
   // and the line store, and predicts one sample per pixel of a supported order.
   class nv12_scoreboard;
      logic [1:0]      byte_order;
      logic [12:0]     width_reg;
      logic [12:0]     height_reg;
      int              col;
      int              row;
      logic [8:0]      held_u;
      logic [8:0]      held_v;
      logic [17:0]     pair_sums [rgbnv_pkg::STORE_DEPTH];
      nv12_sample_type expected_samples [$];
      int              errors;

      function new();
         byte_order = rgbnv_pkg::ORDER_BGR;
         width_reg  = rgbnv_pkg::WIDTH_RESET;
         height_reg = rgbnv_pkg::HEIGHT_RESET;
         errors     = 0;
         restart();
      endfunction

      function void restart();
         col    = 0;
         row    = 0;
         held_u = '0;
         held_v = '0;
      endfunction

      // Register bit 0 is ignored and the size is held within 2..limit.
      function int frame_extent(logic [12:0] value, int limit);
         int s;
         s = int'(value) & ~1;
         if (s < 2) s = 2;
         if (s > limit) s = limit & ~1;
         return s;
      endfunction

      function void apply_write(logic [1:0] index, logic [12:0] value);
         case (index)
            rgbnv_pkg::REG_PIXEL_ORDER:  byte_order = value[1:0];
            rgbnv_pkg::REG_FRAME_WIDTH:  width_reg  = value;
            rgbnv_pkg::REG_FRAME_HEIGHT: height_reg = value;
            default: return;
         endcase
         restart();
      endfunction

      function void note_pixel(logic [23:0] pix);
         int              red, green, blue, y, u, v, w, h, slot, total_u, total_v;
         logic [17:0]     entry;
         nv12_sample_type s;
         if (byte_order != rgbnv_pkg::ORDER_BGR && byte_order != rgbnv_pkg::ORDER_RGB) return;
         green = int'(pix[15:8]);
         if (byte_order == rgbnv_pkg::ORDER_BGR) begin
            blue = int'(pix[7:0]);
            red  = int'(pix[23:16]);
         end else begin
            red  = int'(pix[7:0]);
            blue = int'(pix[23:16]);
         end
         // The 128 * 256 bias keeps the chroma terms non-negative before the shift.
         y = ((66 * red + 129 * green + 25 * blue + 128) >> 8) + 16;
         u = (112 * blue + 32896 - 38 * red - 74 * green) >> 8;
         v = (112 * red + 32896 - 94 * green - 18 * blue) >> 8;
         s.luma         = (y > 255) ? 8'hFF : 8'(y);
         s.chroma_u     = '0;
         s.chroma_v     = '0;
         s.chroma_valid = 1'b0;
         s.frame_end    = 1'b0;
         w    = frame_extent(width_reg, rgbnv_pkg::MAX_WIDTH);
         h    = frame_extent(height_reg, rgbnv_pkg::MAX_HEIGHT);
         slot = (col >> 1) % rgbnv_pkg::STORE_DEPTH;
         if (col % 2 == 0) begin
            held_u = 9'(u);
            held_v = 9'(v);
         end else if (row % 2 == 0) begin
            entry[8:0]  = 9'(held_u + 9'(u));
            entry[17:9] = 9'(held_v + 9'(v));
            pair_sums[slot] = entry;
         end else begin
            entry   = pair_sums[slot];
            total_u = int'(entry[8:0]) + int'(held_u) + u;
            total_v = int'(entry[17:9]) + int'(held_v) + v;
            s.chroma_u     = (total_u / 4 > 255) ? 8'hFF : 8'(total_u / 4);
            s.chroma_v     = (total_v / 4 > 255) ? 8'hFF : 8'(total_v / 4);
            s.chroma_valid = 1'b1;
         end
         if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
               row         = 0;
               s.frame_end = 1'b1;
            end else begin
               row++;
            end
         end else begin
            col++;
         end
         expected_samples.push_back(s);
      endfunction

      function void check_output(logic [23:0] data, logic chroma_flag, logic last);
         nv12_sample_type s;
         if (expected_samples.size() == 0) begin
            $error("result item with no pixel pending: data %h", data);
            errors++;
            return;
         end
         s = expected_samples.pop_front();
         if (data[7:0] !== s.luma) begin
            $error("luma: expected %0d, got %0d", s.luma, data[7:0]);
            errors++;
         end
         if (data[15:8] !== s.chroma_u) begin
            $error("chroma_u: expected %0d, got %0d", s.chroma_u, data[15:8]);
            errors++;
         end
         if (data[23:16] !== s.chroma_v) begin
            $error("chroma_v: expected %0d, got %0d", s.chroma_v, data[23:16]);
            errors++;
         end
         if (chroma_flag !== s.chroma_valid) begin
            $error("chroma_valid: expected %0d, got %0d", s.chroma_valid, chroma_flag);
            errors++;
         end
         if (last !== s.frame_end) begin
            $error("frame_end: expected %0d, got %0d", s.frame_end, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   nv12_scoreboard sb = new();
   int             cycle_count = 0;
   // While set, neither side inserts gaps, so the pipeline runs at full rate.
   bit             full_rate = 0;
   // Byte order the stimulus believes is active, used to count real pixels.
   logic [1:0]     active_order = rgbnv_pkg::ORDER_BGR;

   rgb_to_nv12_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The watchdog ends a run that hangs; the limit is far above the slowest
   // correct run even with every gap at its longest.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rgb_to_nv12_converter_top verification failed");
         $finish;
      end
   end

   // Monitors. Right after the edge the signals still hold their pre-edge values,
   // since both the bench and the block update through nonblocking assignments.
   // Register writes and accepted pixels feed the predictor; accepted results are
   // checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) sb.note_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tuser[0], rsp_tlast);
      end
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (full_rate) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Color bytes lean on the ends of the range so that the extremes show up often.
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Result side: stall stretches of random length between runs of readiness.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   // Offers one pixel after an optional gap and returns at the edge that takes it.
   // tvalid stays high when the next pixel follows without a gap.
   task automatic send_pixel(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] third);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {third, second, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering pixels and waits until every predicted result has come out.
   // Extra idle cycles follow; pixels dropped under an unsupported order give no
   // result and never enter the pipeline.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_samples.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the idle wait after it keeps back-to-back writes apart.
   task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index == rgbnv_pkg::REG_PIXEL_ORDER) active_order = value[1:0];
   endtask

   // Frame size for the random part: mostly small even sizes, some odd and
   // medium ones, and now and then the extremes, zero among them, including
   // values past the largest supported size that must saturate.
   function automatic logic [12:0] pick_size(input int small_max);
      int roll;
      logic [12:0] extremes [8] = '{13'd0, 13'd1, 13'd2, 13'd4095, 13'd4096,
                                    13'd4097, 13'd8190, 13'd8191};
      roll = $urandom_range(0, 99);
      if (roll < 70) return 13'(2 * $urandom_range(1, small_max / 2));
      if (roll < 82) return 13'(2 * $urandom_range(0, small_max / 2) + 1);
      if (roll < 92) return 13'($urandom_range(18, 64));
      return extremes[$urandom_range(0, 7)];
   endfunction

   initial begin
      int pixel_total;
      int phase_len;
      int w_used;
      reset      <= 1'b1;
      csr_wr_en  <= 1'b0;
      csr_index  <= rgbnv_pkg::REG_PIXEL_ORDER;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Two-by-two frames in blue-green-red order: black, white,
      // each pure primary and the pairwise mixes, so each frame closes a block.
      write_reg(rgbnv_pkg::REG_FRAME_WIDTH, 13'd2);
      write_reg(rgbnv_pkg::REG_FRAME_HEIGHT, 13'd2);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      drain();

      // Some of the same extremes with red first.
      write_reg(rgbnv_pkg::REG_PIXEL_ORDER, rgbnv_pkg::ORDER_RGB);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      drain();

      // Both unsupported orders: pixels are taken and dropped without a result.
      write_reg(rgbnv_pkg::REG_PIXEL_ORDER, ORDER_NONE_A);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      drain();
      write_reg(rgbnv_pkg::REG_PIXEL_ORDER, ORDER_NONE_B);
      send_pixel(8'hA5, 8'h5A, 8'hC3);
      send_pixel(8'h3C, 8'h96, 8'h69);
      drain();

      // An odd width of five is used as four and a height of one as two. A
      // write to the unused index midway must not restart the frame, so the
      // eighth pixel still closes it.
      write_reg(rgbnv_pkg::REG_PIXEL_ORDER, rgbnv_pkg::ORDER_BGR);
      write_reg(rgbnv_pkg::REG_FRAME_WIDTH, 13'd5);
      write_reg(rgbnv_pkg::REG_FRAME_HEIGHT, 13'd1);
      repeat (3) send_pixel(pick_byte(), pick_byte(), pick_byte());
      drain();
      write_reg(REG_UNUSED, 13'h1FFF);
      repeat (5) send_pixel(pick_byte(), pick_byte(), pick_byte());
      drain();

      // Random part, in phases. Every phase begins with the block idle, which is
      // also where the sender holds off until all results are in. Each register
      // may be rewritten; a phase without writes continues the frame in progress.
      pixel_total = 0;
      while (pixel_total < RANDOM_PIXELS) begin
         if ($urandom_range(0, 99) < 40) begin
            if ($urandom_range(0, 9) == 0)
               write_reg(rgbnv_pkg::REG_PIXEL_ORDER,
                         $urandom_range(0, 1) ? ORDER_NONE_A : ORDER_NONE_B);
            else
               write_reg(rgbnv_pkg::REG_PIXEL_ORDER,
                         $urandom_range(0, 1) ? rgbnv_pkg::ORDER_RGB : rgbnv_pkg::ORDER_BGR);
         end
         // An unsupported order left behind by the last phase is cleared most of
         // the time, so that dropped pixels stay a small share of the stimulus.
         if ((active_order == ORDER_NONE_A || active_order == ORDER_NONE_B) &&
             $urandom_range(0, 3) != 0)
            write_reg(rgbnv_pkg::REG_PIXEL_ORDER, rgbnv_pkg::ORDER_BGR);
         if ($urandom_range(0, 99) < 40) write_reg(rgbnv_pkg::REG_FRAME_WIDTH, pick_size(16));
         if ($urandom_range(0, 99) < 40) write_reg(rgbnv_pkg::REG_FRAME_HEIGHT, pick_size(8));
         if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, 13'($urandom_range(0, 8191)));

         full_rate = ($urandom_range(0, 3) == 0);
         w_used    = sb.frame_extent(sb.width_reg, rgbnv_pkg::MAX_WIDTH);
         if (active_order == ORDER_NONE_A || active_order == ORDER_NONE_B)
            phase_len = $urandom_range(4, 12);
         else if (w_used > 64)
            phase_len = 150;
         else
            phase_len = $urandom_range(20, 120);

         repeat (phase_len) send_pixel(pick_byte(), pick_byte(), pick_byte());
         if (active_order == rgbnv_pkg::ORDER_BGR || active_order == rgbnv_pkg::ORDER_RGB)
            pixel_total += phase_len;
         drain();
      end

      full_rate = 0;
      drain();
      if (sb.errors == 0 && sb.expected_samples.size() == 0) begin
         $display("rgb_to_nv12_converter_top verification clean");
      end else begin
         $display("rgb_to_nv12_converter_top verification failed");
      end
      $finish;
   end

endmodule

FILE: rgb_to_nv12_converter_top.f
+incdir+hdl
hdl/rgbnv_pkg.sv
hdl/rgbnv_ram.sv
hdl/rgb_to_nv12_converter_top.sv
hdl/rgbnv_checker.sv
bench/rgb_to_nv12_converter_top_tb.sv
